>>> hw/rtl/cidr_pkg.sv
// ----------------------------------------------------------------------------
// CIDR parser package
// Beat types, running parse state and constants shared by the parser blocks.
// ----------------------------------------------------------------------------
package cidr_pkg;

  localparam logic [31:0] ALL_ONES     = 32'hFFFF_FFFF;
  localparam logic [5:0]  PREFIX_MAX   = 6'd32;
  localparam logic [5:0]  PREFIX_SAT   = 6'd33;
  localparam logic [8:0]  OCTET_SAT    = 9'd256;
  localparam logic [8:0]  OCTET_MAX    = 9'd255;
  localparam logic [2:0]  SLASH_MIN    = 3'd7;
  localparam logic [2:0]  LAST_OCT     = 3'd3;
  localparam logic [2:0]  CNT_SAT      = 3'd7;

  localparam logic [7:0]  CHAR_ZERO    = 8'h30;
  localparam logic [7:0]  CHAR_NINE    = 8'h39;
  localparam logic [7:0]  CHAR_DOT     = 8'h2E;
  localparam logic [7:0]  CHAR_SLASH   = 8'h2F;

  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_FORMAT = 2'd1,
    STATUS_OCTET  = 2'd2
  } parse_status_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } char_beat_t;

  typedef struct packed {
    logic [31:0]   ip_address;
    logic [31:0]   net_mask;
    parse_status_t parse_status;
  } result_beat_t;

  typedef struct packed {
    logic [31:0] address_accumulator;
    logic [8:0]  octet_value;
    logic [2:0]  dot_count;
    logic [2:0]  char_position;
    logic        slash_seen;
    logic [5:0]  prefix_length;
    logic        format_error;
    logic        octet_error;
  } parse_state_t;

  localparam parse_state_t STATE_CLEAR = '0;

endpackage

>>> hw/rtl/cidr_state.sv
// ----------------------------------------------------------------------------
// CIDR parser running state
// Decodes one character per beat and updates the running address, octet,
// prefix and error flags; returns to the clear state after the last beat.
// ----------------------------------------------------------------------------
module cidr_state
  import cidr_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         take,
  input  char_beat_t   beat,
  output parse_state_t upd
);

  parse_state_t st;

  always_comb begin
    logic        is_digit;
    logic        is_dot;
    logic        is_slash;
    logic [3:0]  digit;
    logic [11:0] oct_prod;
    logic [8:0]  pfx_prod;
    logic [31:0] placed;

    is_digit = (beat.char_code >= CHAR_ZERO) && (beat.char_code <= CHAR_NINE);
    is_dot   = (beat.char_code == CHAR_DOT);
    is_slash = (beat.char_code == CHAR_SLASH);
    digit    = is_digit ? beat.char_code[3:0] : 4'd0;
    oct_prod = 12'(st.octet_value) * 12'd10 + 12'(digit);
    pfx_prod = 9'(st.prefix_length) * 9'd10 + 9'(digit);
    placed   = {24'd0, st.octet_value[7:0]} << {~st.dot_count[1:0], 3'b000};

    upd = st;
    if (!is_digit && !is_dot && !is_slash) begin
      upd.format_error = 1'b1;
    end else if (st.slash_seen) begin
      if (is_digit) begin
        upd.prefix_length = (pfx_prod > 9'(PREFIX_SAT)) ? PREFIX_SAT : pfx_prod[5:0];
      end else begin
        upd.format_error = 1'b1;
      end
    end else if (is_slash) begin
      upd.slash_seen = 1'b1;
      if (st.char_position < SLASH_MIN) begin
        upd.format_error = 1'b1;
      end
    end else if (is_dot) begin
      if (st.dot_count > LAST_OCT) begin
        upd.octet_error = 1'b1;
      end else begin
        upd.address_accumulator = st.address_accumulator | placed;
        upd.octet_value         = '0;
      end
      if (st.dot_count != CNT_SAT) begin
        upd.dot_count = st.dot_count + 3'd1;
      end
    end else begin
      upd.octet_value = (oct_prod > 12'(OCTET_SAT)) ? OCTET_SAT : oct_prod[8:0];
      if ((oct_prod > 12'(OCTET_MAX)) || (st.dot_count > LAST_OCT)) begin
        upd.octet_error = 1'b1;
      end
    end
    if (st.char_position != CNT_SAT) begin
      upd.char_position = st.char_position + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= STATE_CLEAR;
    end else if (take) begin
      st <= beat.last_char ? STATE_CLEAR : upd;
    end
  end

endmodule

>>> hw/rtl/cidr_result.sv
// ----------------------------------------------------------------------------
// CIDR parser result stage
// Forms address, mask and status from the updated state and holds the
// result beat until the downstream side takes it.
// ----------------------------------------------------------------------------
module cidr_result
  import cidr_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         load,
  input  parse_state_t upd,
  input  logic         result_stall,
  output logic         result_valid,
  output result_beat_t result_beat
);

  result_beat_t res_next;

  always_comb begin
    res_next = '{ip_address: '0, net_mask: '0, parse_status: STATUS_OK};
    if (upd.format_error || (upd.slash_seen && (upd.prefix_length > PREFIX_MAX))) begin
      res_next.parse_status = STATUS_FORMAT;
    end else if (upd.octet_error) begin
      res_next.parse_status = STATUS_OCTET;
    end else begin
      res_next.ip_address = upd.address_accumulator | {24'd0, upd.octet_value[7:0]};
      res_next.net_mask   = upd.slash_seen ? ~(ALL_ONES >> upd.prefix_length) : ALL_ONES;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_beat <= res_next;
    end
  end

endmodule

>>> hw/rtl/cidr_address_text_parser.sv
// ----------------------------------------------------------------------------
// CIDR address text parser
// Parses a.b.c.d/n one character per beat; emits address, mask and status.
// Latency: result beat is valid the cycle after the last character is taken.
// Throughput: one character per cycle, limited only by the result register.
// Reset: synchronous; clears parse state and the result valid flag.
// ----------------------------------------------------------------------------
module cidr_address_text_parser
  import cidr_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         char_valid,
  output logic         char_stall,
  input  char_beat_t   char_beat,
  output logic         result_valid,
  input  logic         result_stall,
  output result_beat_t result_beat
);

  parse_state_t upd;
  logic         take;

  assign char_stall = result_valid && result_stall;
  assign take       = char_valid && !char_stall;

  cidr_state u_state (
    .clk  (clk),
    .rst  (rst),
    .take (take),
    .beat (char_beat),
    .upd  (upd)
  );

  cidr_result u_result (
    .clk          (clk),
    .rst          (rst),
    .load         (take && char_beat.last_char),
    .upd          (upd),
    .result_stall (result_stall),
    .result_valid (result_valid),
    .result_beat  (result_beat)
  );

endmodule

>>> bench/cidr_result_checker.sv
// ----------------------------------------------------------------------------
// CIDR parser result checker
// Watches the character and result channels. It runs its own parse of every
// accepted character beat, queues the address/mask/status that each final
// character should produce, and compares every accepted result beat, field by
// field, against the oldest queued one. It counts mismatches for the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module cidr_result_checker
  import cidr_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         char_valid,
  input  logic         char_stall,
  input  char_beat_t   char_beat,
  input  logic         result_valid,
  input  logic         result_stall,
  input  result_beat_t result_beat,
  output int           fail_count,
  output int           pending
);

  parse_state_t parse_state;
  result_beat_t expected_results[$];
  result_beat_t want;

  initial begin
    fail_count = 0;
    pending = 0;
    parse_state = STATE_CLEAR;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
    $display("%0t: %s mismatch, got %h, expected %h", $time, what, got, exp_val);
    fail_count++;
  endtask

  // Advance the parse by one character; queue a result on the final one.
  task automatic parse_char(input char_beat_t beat);
    logic [7:0]   c;
    bit           is_digit, is_dot, is_slash;
    int           v;
    result_beat_t res;
    c = beat.char_code;
    is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    is_dot = (c == CHAR_DOT);
    is_slash = (c == CHAR_SLASH);
    res = '0;
    if (!is_digit && !is_dot && !is_slash) begin
      parse_state.format_error = 1'b1;
    end else if (parse_state.slash_seen) begin
      if (is_digit) begin
        v = parse_state.prefix_length * 10 + (c - CHAR_ZERO);
        parse_state.prefix_length = (v > PREFIX_SAT) ? PREFIX_SAT : v[5:0];
      end else begin
        parse_state.format_error = 1'b1;
      end
    end else if (is_slash) begin
      parse_state.slash_seen = 1'b1;
      if (parse_state.char_position < SLASH_MIN) parse_state.format_error = 1'b1;
    end else if (is_dot) begin
      if (parse_state.dot_count > LAST_OCT) begin
        parse_state.octet_error = 1'b1;
      end else begin
        parse_state.address_accumulator |= {24'd0, parse_state.octet_value[7:0]}
                                           << (8 * (LAST_OCT - parse_state.dot_count));
        parse_state.octet_value = '0;
      end
      if (parse_state.dot_count < CNT_SAT) parse_state.dot_count++;
    end else begin
      v = parse_state.octet_value * 10 + (c - CHAR_ZERO);
      parse_state.octet_value = (v > OCTET_SAT) ? OCTET_SAT : v[8:0];
      if (parse_state.octet_value > OCTET_MAX || parse_state.dot_count > LAST_OCT) begin
        parse_state.octet_error = 1'b1;
      end
    end
    if (parse_state.char_position < CNT_SAT) parse_state.char_position++;

    if (beat.last_char) begin
      if (parse_state.format_error ||
          (parse_state.slash_seen && parse_state.prefix_length > PREFIX_MAX)) begin
        res.parse_status = STATUS_FORMAT;
      end else if (parse_state.octet_error) begin
        res.parse_status = STATUS_OCTET;
      end else begin
        res.parse_status = STATUS_OK;
        res.ip_address = parse_state.address_accumulator
                         | {24'd0, parse_state.octet_value[7:0]};
        if (!parse_state.slash_seen) begin
          res.net_mask = ALL_ONES;
        end else if (parse_state.prefix_length == 0) begin
          res.net_mask = '0;
        end else begin
          res.net_mask = ALL_ONES << (PREFIX_MAX - parse_state.prefix_length);
        end
      end
      expected_results.push_back(res);
      parse_state = STATE_CLEAR;
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (char_valid && !char_stall) parse_char(char_beat);
      if (result_valid && !result_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result beat", result_beat.ip_address, '0);
        end else begin
          want = expected_results.pop_front();
          if (result_beat.ip_address !== want.ip_address) begin
            report_mismatch("ip_address", result_beat.ip_address, want.ip_address);
          end
          if (result_beat.net_mask !== want.net_mask) begin
            report_mismatch("net_mask", result_beat.net_mask, want.net_mask);
          end
          if (result_beat.parse_status !== want.parse_status) begin
            report_mismatch("parse_status", {30'd0, result_beat.parse_status},
                            {30'd0, want.parse_status});
          end
        end
      end
      pending = expected_results.size();
    end
  end

endmodule

>>> bench/tb_top.sv
// ----------------------------------------------------------------------------
// CIDR address text parser testbench
// Feeds address texts one character beat at a time: a few directed texts for
// the corner cases, then random well-formed, corrupted and noise texts, with
// random gaps on the sender and random stalls (plus long hold-offs) on the
// result side. The checker module predicts and compares; this top only makes
// stimulus and gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
  import cidr_pkg::*;

  logic         clk;
  logic         rst = 1'b1;
  logic         char_valid = 1'b0;
  logic         char_stall;
  char_beat_t   char_beat = '0;
  logic         result_valid;
  logic         result_stall = 1'b0;
  result_beat_t result_beat;
  int           fail_count;
  int           pending;

  int           chars_sent = 0;
  bit           gaps_on = 1'b1;
  logic [7:0]   text_q[$];

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  cidr_address_text_parser uut (
    .clk          (clk),
    .rst          (rst),
    .char_valid   (char_valid),
    .char_stall   (char_stall),
    .char_beat    (char_beat),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_beat  (result_beat)
  );

  cidr_result_checker chk (
    .clk          (clk),
    .rst          (rst),
    .char_valid   (char_valid),
    .char_stall   (char_stall),
    .char_beat    (char_beat),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_beat  (result_beat),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int idle_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return 0;
    if (roll < 96) return $urandom_range(1, 3);
    return $urandom_range(12, 40);
  endfunction

  function automatic logic [7:0] noise_char();
    case ($urandom_range(0, 4))
      0, 1: return 8'($urandom_range(0, 255));
      2: return CHAR_DOT;
      3: return CHAR_SLASH;
      default: return 8'($urandom_range(CHAR_ZERO, CHAR_NINE));
    endcase
  endfunction

  function automatic int octet_pick();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) return 255;
    if (roll < 18) return 0;
    if (roll < 88) return $urandom_range(0, 255);
    if (roll < 97) return $urandom_range(256, 999);
    return $urandom_range(1000, 99999);
  endfunction

  task automatic add_number(input int v);
    string s;
    s = $sformatf("%0d", v);
    if ($urandom_range(0, 19) == 0) text_q.push_back(CHAR_ZERO);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  task automatic make_text();
    int kind, octets, roll, pos;
    logic [7:0] pick;
    text_q.delete();
    kind = $urandom_range(0, 99);
    if (kind < 12) begin
      repeat ($urandom_range(1, 12)) text_q.push_back(noise_char());
    end else begin
      octets = ($urandom_range(0, 3) != 0) ? 4 : $urandom_range(1, 6);
      for (int i = 0; i < octets; i++) begin
        if (i != 0) text_q.push_back(CHAR_DOT);
        if ($urandom_range(0, 39) != 0) add_number(octet_pick());
      end
      if ($urandom_range(0, 3) != 0) begin
        text_q.push_back(CHAR_SLASH);
        roll = $urandom_range(0, 99);
        if (roll < 80) add_number($urandom_range(0, 32));
        else if (roll < 90) add_number($urandom_range(33, 999));
      end
      // corrupted text: overwrite or insert one character
      if (kind >= 85) begin
        pos = $urandom_range(0, text_q.size());
        pick = noise_char();
        if ($urandom_range(0, 1) == 0) text_q.insert(pos, pick);
        else if (pos < text_q.size()) text_q[pos] = pick;
        else text_q.push_back(pick);
      end
    end
    if (text_q.size() == 0) text_q.push_back(CHAR_ZERO);
  endtask

  // Called at a rising edge; returns at the edge where the beat is taken.
  task automatic send_char(input logic [7:0] code, input logic last);
    int  gap;
    bit  taken;
    gap = gaps_on ? idle_len() : 0;
    repeat (gap) begin
      char_valid <= 1'b0;
      @(posedge clk);
    end
    char_valid <= 1'b1;
    char_beat <= '{char_code: code, last_char: last};
    do begin
      @(negedge clk);
      taken = !char_stall;
      @(posedge clk);
    end while (!taken);
    chars_sent++;
  endtask

  task automatic send_string(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  initial begin : stimulus
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_char(8'h00, 1'b1);
    send_char(8'hFF, 1'b1);
    send_string("/");
    send_string("256");
    send_string("....9");
    send_string("1.2");
    send_string("0.0.0.0/0");
    send_string("256.1.1.1/33");

    while (chars_sent < 1400) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      make_text();
      for (int i = 0; i < text_q.size(); i++) begin
        send_char(text_q[i], i == text_q.size() - 1);
      end
    end
    char_valid <= 1'b0;

    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Result side: random stalls, calm stretches, and two long hold-offs.
  initial begin : result_sink
    int cycle, stall_left;
    bit calm;
    cycle = 0;
    stall_left = 0;
    calm = 1'b0;
    forever begin
      @(posedge clk);
      cycle++;
      if (cycle % 700 == 0) calm = ($urandom_range(0, 2) == 0);
      if (cycle == 1500 || cycle == 4000) begin
        stall_left = 400;
      end else if (stall_left == 0 && !calm && $urandom_range(0, 4) == 0) begin
        stall_left = idle_len();
      end
      if (stall_left > 0) begin
        result_stall <= 1'b1;
        stall_left--;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

>>> files.f
hw/rtl/cidr_pkg.sv
hw/rtl/cidr_state.sv
hw/rtl/cidr_result.sv
hw/rtl/cidr_address_text_parser.sv
bench/cidr_result_checker.sv
bench/tb_top.sv
